[design/ffsa_pkg.sv]
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared widths, request and status codes and memory control type for the
// first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int DEF_REGION_BYTES = 4096;
   localparam int DEF_MAX_SEGMENTS = 32;

   localparam int REQ_SIZE_W = 13;
   localparam int REQ_ADDR_W = 12;
   localparam int STATUS_W   = 3;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_SPACE   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_ZERO_SIZE  = 3'd4;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[design/ffsa_if.sv]
// ----------------------------------------------------------------------------
// ffsa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ffsa_req_if
   import ffsa_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [REQ_SIZE_W-1:0] req_size;
   logic [REQ_ADDR_W-1:0] req_addr;

   modport source (output valid, req_type, req_size, req_addr, input ready);
   modport sink   (input valid, req_type, req_size, req_addr, output ready);
endinterface

interface ffsa_rsp_if
   import ffsa_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [REQ_ADDR_W-1:0] result_addr;

   modport source (output valid, status, result_addr, input ready);
   modport sink   (input valid, status, result_addr, output ready);
endinterface

[design/first_fit_segment_allocator.sv]
// A zero-size allocate is answered without a scan; otherwise the scan reads one entry per cycle
// and stops at the first free entry that fits, or answers a miss after the last entry.
// A split first moves every entry above the match up by one; a free then moves the entries
// above the merged ones down to close the gap.
// One request at a time; ready drops on acceptance and returns as the response is registered.
// Reset leaves one free segment covering the region, usable in the next cycle.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered segment table, with splitting on
// allocate and coalescing of adjacent free neighbors on free.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
   import ffsa_pkg::*;
#(
   parameter int REGION_BYTES = DEF_REGION_BYTES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic       clock,
   input  logic       reset,
   ffsa_req_if.sink   req_ch,
   ffsa_rsp_if.source rsp_ch
);

   localparam int AW   = $clog2(REGION_BYTES);
   localparam int LW   = $clog2(REGION_BYTES + 1);
   localparam int EW   = AW + LW + 1;
   localparam int IW   = $clog2(MAX_SEGMENTS);
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int CW   = (AW > REQ_ADDR_W) ? AW : REQ_ADDR_W;
   localparam int SW   = (LW > REQ_SIZE_W) ? LW : REQ_SIZE_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_GROW,
      S_SPLIT_LO,
      S_SPLIT_HI,
      S_FREE_NXT,
      S_FREE_MRG,
      S_SHRINK,
      S_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [CNTW-1:0]       count_ff, count_in;
   logic [CNTW-1:0]       ptr_ff, ptr_in;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [IW-1:0]         pipe_idx_ff, pipe_idx_in;
   logic                  op_ff, op_in;
   logic [SW-1:0]         size_ff, size_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic [IW-1:0]         f_idx_ff, f_idx_in;
   logic [AW-1:0]         f_start_ff, f_start_in;
   logic [LW-1:0]         f_len_ff, f_len_in;
   logic                  prev_free_ff, prev_free_in;
   logic [LW-1:0]         prev_end_ff, prev_end_in;
   logic [AW-1:0]         prev_start_ff, prev_start_in;
   logic [LW-1:0]         prev_len_ff, prev_len_in;
   logic                  mp_ff, mp_in;
   logic                  mn_ff, mn_in;
   logic [LW-1:0]         nxt_len_ff, nxt_len_in;
   logic [LW-1:0]         end_ff, end_in;
   logic [LW-1:0]         acc_ff, acc_in;
   logic [AW-1:0]         tmp_start_ff, tmp_start_in;
   logic [1:0]            rem_r_ff, rem_r_in;
   logic [STATUS_W-1:0]   stat_ff, stat_in;
   logic [REQ_ADDR_W-1:0] raddr_ff, raddr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [REQ_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   mem_ctl_type   mem_ctl;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;

   logic [AW-1:0] rd_start;
   logic [LW-1:0] rd_len;
   logic          rd_used;
   logic [LW-1:0] ent_end;
   logic [CW-1:0] rd_start_c;
   logic          issue;
   logic          req_fire;

   ffsa_seg_mem #(
      .REGION_BYTES (REGION_BYTES),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_seg_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign rd_start   = rd_data[EW-1 -: AW];
   assign rd_len     = rd_data[LW:1];
   assign rd_used    = rd_data[0];
   assign ent_end    = LW'(rd_start) + rd_len;
   assign rd_start_c = CW'(rd_start);

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign req_fire           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pipe_vld_in   = pipe_vld_ff;
      pipe_idx_in   = pipe_idx_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      f_idx_in      = f_idx_ff;
      f_start_in    = f_start_ff;
      f_len_in      = f_len_ff;
      prev_free_in  = prev_free_ff;
      prev_end_in   = prev_end_ff;
      prev_start_in = prev_start_ff;
      prev_len_in   = prev_len_ff;
      mp_in         = mp_ff;
      mn_in         = mn_ff;
      nxt_len_in    = nxt_len_ff;
      end_in        = end_ff;
      acc_in        = acc_ff;
      tmp_start_in  = tmp_start_ff;
      rem_r_in      = rem_r_ff;
      stat_in       = stat_ff;
      raddr_in      = raddr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      mem_ctl       = '0;
      rd_addr       = ptr_ff[IW-1:0];
      wr_addr       = '0;
      wr_data       = '0;
      issue         = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in        = req_ch.req_type;
               size_in      = SW'(req_ch.req_size);
               addr_in      = CW'(req_ch.req_addr);
               ptr_in       = '0;
               pipe_vld_in  = 1'b0;
               prev_free_in = 1'b0;
               raddr_in     = '0;
               if ((req_ch.req_type == REQ_ALLOC) && (req_ch.req_size == '0)) begin
                  stat_in  = STAT_ZERO_SIZE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            // one read issued per cycle, checked the cycle after
            issue = (ptr_ff < count_ff);
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               ptr_in        = ptr_ff + 1'b1;
               pipe_idx_in   = ptr_ff[IW-1:0];
            end
            pipe_vld_in = issue;
            if (pipe_vld_ff) begin
               if (op_ff == REQ_ALLOC) begin
                  if (!rd_used && (SW'(rd_len) >= size_ff)) begin
                     f_idx_in   = pipe_idx_ff;
                     f_start_in = rd_start;
                     f_len_in   = rd_len;
                     if (SW'(rd_len) == size_ff) begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = pipe_idx_ff;
                        wr_data       = {rd_start, rd_len, 1'b1};
                        stat_in       = STAT_OK;
                        raddr_in      = rd_start_c[REQ_ADDR_W-1:0];
                        state_in      = S_RESP;
                     end else if (count_ff == CNTW'(MAX_SEGMENTS)) begin
                        stat_in  = STAT_TABLE_FULL;
                        state_in = S_RESP;
                     end else begin
                        stat_in     = STAT_OK;
                        raddr_in    = rd_start_c[REQ_ADDR_W-1:0];
                        ptr_in      = count_ff - 1'b1;
                        pipe_vld_in = 1'b0;
                        state_in    = S_GROW;
                     end
                  end
               end else begin
                  if (rd_used && (rd_start_c == addr_ff)) begin
                     f_idx_in   = pipe_idx_ff;
                     f_start_in = rd_start;
                     f_len_in   = rd_len;
                     mp_in      = prev_free_ff && (prev_end_ff == LW'(rd_start));
                     end_in     = ent_end;
                     // the read issued this cycle is the following entry
                     state_in   = S_FREE_NXT;
                  end else begin
                     prev_free_in  = !rd_used;
                     prev_end_in   = ent_end;
                     prev_start_in = rd_start;
                     prev_len_in   = rd_len;
                  end
               end
            end else if (!issue) begin
               stat_in  = (op_ff == REQ_ALLOC) ? STAT_NO_SPACE : STAT_NOT_FOUND;
               state_in = S_RESP;
            end
         end

         S_GROW: begin
            // move entries above the split up by one, top first
            issue = (ptr_ff > CNTW'(f_idx_ff));
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               ptr_in        = ptr_ff - 1'b1;
               pipe_idx_in   = ptr_ff[IW-1:0];
            end
            pipe_vld_in = issue;
            if (pipe_vld_ff) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = pipe_idx_ff + 1'b1;
               wr_data       = rd_data;
            end else if (!issue) begin
               state_in = S_SPLIT_LO;
            end
         end

         S_SPLIT_LO: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = f_idx_ff;
            wr_data       = {f_start_ff, LW'(size_ff), 1'b1};
            tmp_start_in  = AW'(SW'(f_start_ff) + size_ff);
            state_in      = S_SPLIT_HI;
         end

         S_SPLIT_HI: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = f_idx_ff + 1'b1;
            wr_data       = {tmp_start_ff, LW'(SW'(f_len_ff) - size_ff), 1'b0};
            count_in      = count_ff + 1'b1;
            state_in      = S_RESP;
         end

         S_FREE_NXT: begin
            acc_in     = f_len_ff + (mp_ff ? prev_len_ff : '0);
            mn_in      = pipe_vld_ff && !rd_used && (end_ff == LW'(rd_start));
            nxt_len_in = rd_len;
            state_in   = S_FREE_MRG;
         end

         S_FREE_MRG: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = mp_ff ? (f_idx_ff - 1'b1) : f_idx_ff;
            wr_data       = {mp_ff ? prev_start_ff : f_start_ff,
                             acc_ff + (mn_ff ? nxt_len_ff : '0), 1'b0};
            rem_r_in      = {1'b0, mp_ff} + {1'b0, mn_ff};
            ptr_in        = CNTW'(f_idx_ff) + CNTW'(1) + CNTW'(mn_ff);
            pipe_vld_in   = 1'b0;
            stat_in       = STAT_OK;
            raddr_in      = '0;
            state_in      = S_SHRINK;
         end

         S_SHRINK: begin
            // close the gap left by merged entries, bottom first
            issue = (ptr_ff < count_ff);
            if (issue) begin
               mem_ctl.rd_en = 1'b1;
               ptr_in        = ptr_ff + 1'b1;
               pipe_idx_in   = ptr_ff[IW-1:0];
            end
            pipe_vld_in = issue;
            if (pipe_vld_ff) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = pipe_idx_ff - IW'(rem_r_ff);
               wr_data       = rd_data;
            end else if (!issue) begin
               count_in = count_ff - CNTW'(rem_r_ff);
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_addr_in   = raddr_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNTW'(1);
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      pipe_idx_ff   <= pipe_idx_in;
      op_ff         <= op_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      f_idx_ff      <= f_idx_in;
      f_start_ff    <= f_start_in;
      f_len_ff      <= f_len_in;
      prev_free_ff  <= prev_free_in;
      prev_end_ff   <= prev_end_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      mp_ff         <= mp_in;
      mn_ff         <= mn_in;
      nxt_len_ff    <= nxt_len_in;
      end_ff        <= end_in;
      acc_ff        <= acc_in;
      tmp_start_ff  <= tmp_start_in;
      rem_r_ff      <= rem_r_in;
      stat_ff       <= stat_in;
      raddr_ff      <= raddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNTW'(MAX_SEGMENTS)))
      else $error("segment count out of range");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
      else $error("table read and write hit the same entry");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request taken while previous one in flight");

   a_split_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT_HI) |-> (count_ff < CNTW'(MAX_SEGMENTS)))
      else $error("split with a full table");

   a_fail_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_addr_ff == '0))
      else $error("failed request carries an address");

endmodule

[design/ffsa_seg_mem.sv]
// ----------------------------------------------------------------------------
// ffsa_seg_mem
// Segment table memory, one write and one registered read per cycle.
// Entry 0 reads as the whole free region until it is first written.
// ----------------------------------------------------------------------------
module ffsa_seg_mem
   import ffsa_pkg::*;
#(
   parameter int REGION_BYTES = DEF_REGION_BYTES,
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  mem_ctl_type                             ctl,
   input  logic [$clog2(MAX_SEGMENTS)-1:0]         rd_addr,
   input  logic [$clog2(MAX_SEGMENTS)-1:0]         wr_addr,
   input  logic [$clog2(REGION_BYTES)+$clog2(REGION_BYTES+1):0] wr_data,
   output logic [$clog2(REGION_BYTES)+$clog2(REGION_BYTES+1):0] rd_data
);

   localparam int AW = $clog2(REGION_BYTES);
   localparam int LW = $clog2(REGION_BYTES + 1);
   localparam int EW = AW + LW + 1;
   localparam logic [EW-1:0] RESET_ENTRY = {{AW{1'b0}}, LW'(REGION_BYTES), 1'b0};

   logic [EW-1:0] mem [MAX_SEGMENTS];
   logic [EW-1:0] rd_raw_ff;
   logic          use_reset_ff;
   logic          e0_written_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_raw_ff    <= mem[rd_addr];
         use_reset_ff <= (rd_addr == '0) && !e0_written_ff;
      end
   end

   // entry 0 keeps its reset contents until the first write lands there
   always_ff @(posedge clock) begin
      if (reset) begin
         e0_written_ff <= 1'b0;
      end else if (ctl.wr_en && (wr_addr == '0)) begin
         e0_written_ff <= 1'b1;
      end
   end

   assign rd_data = use_reset_ff ? RESET_ENTRY : rd_raw_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Random and directed requests against the first-fit segment allocator. A
// local copy of the segment table predicts status and offset for every
// accepted request, and the responses are checked in order.
// ----------------------------------------------------------------------------
module testbench;
   import ffsa_pkg::*;

   localparam int NSEG        = DEF_MAX_SEGMENTS;
   localparam int REGION      = DEF_REGION_BYTES;
   localparam int RAND_REQS   = 1200;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic                  kind;
      logic [REQ_SIZE_W-1:0] size;
      logic [REQ_ADDR_W-1:0] addr;
   } alloc_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [REQ_ADDR_W-1:0] addr;
   } alloc_reply_type;

   logic clock = 1'b0;
   logic reset;

   ffsa_req_if req_if ();
   ffsa_rsp_if rsp_if ();

   first_fit_segment_allocator #(
      .REGION_BYTES(REGION),
      .MAX_SEGMENTS(NSEG)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted segment table
   bit [REQ_SIZE_W-1:0] seg_base [NSEG];
   bit [REQ_SIZE_W-1:0] seg_len  [NSEG];
   bit                  seg_busy [NSEG];
   int                  seg_total;

   alloc_req_type   pending_reqs[$];
   alloc_reply_type replies_due[$];
   int              mismatches = 0;
   int              accepted_reqs = 0;
   int              cycle_count = 0;
   logic            req_done = 1'b0;
   logic            rsp_done = 1'b0;
   logic            hold_rsp = 1'b0;
   logic            calm = 1'b0;
   int              req_gap = 0;
   int              rsp_stall = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic void seg_forget(int idx);
      if (idx >= seg_total) return;
      for (int k = idx; k + 1 < seg_total; k++) begin
         seg_base[k] = seg_base[k + 1];
         seg_len[k]  = seg_len[k + 1];
         seg_busy[k] = seg_busy[k + 1];
      end
      seg_total--;
      seg_base[seg_total] = '0;
      seg_len[seg_total]  = '0;
      seg_busy[seg_total] = 1'b0;
   endfunction

   function automatic void seg_make_room(int idx);
      if (seg_total >= NSEG || idx > seg_total) return;
      for (int k = seg_total; k > idx; k--) begin
         seg_base[k] = seg_base[k - 1];
         seg_len[k]  = seg_len[k - 1];
         seg_busy[k] = seg_busy[k - 1];
      end
      seg_total++;
   endfunction

   function automatic alloc_reply_type grant_alloc(logic [REQ_SIZE_W-1:0] size);
      alloc_reply_type r;
      r.status = STAT_NO_SPACE;
      r.addr   = '0;
      if (size == 0) begin
         r.status = STAT_ZERO_SIZE;
         return r;
      end
      for (int i = 0; i < seg_total; i++) begin
         if (seg_busy[i] || seg_len[i] < size) continue;
         if (seg_len[i] > size) begin
            // first fit must split, but no slot left for the remainder
            if (seg_total >= NSEG) begin
               r.status = STAT_TABLE_FULL;
               return r;
            end
            seg_make_room(i);
            seg_len[i]      = size;
            seg_busy[i]     = 1'b1;
            seg_base[i + 1] = seg_base[i] + size;
            seg_len[i + 1]  = seg_len[i + 1] - size;
            seg_busy[i + 1] = 1'b0;
         end else begin
            seg_busy[i] = 1'b1;
         end
         r.status = STAT_OK;
         r.addr   = seg_base[i][REQ_ADDR_W-1:0];
         return r;
      end
      return r;
   endfunction

   function automatic alloc_reply_type release_seg(logic [REQ_ADDR_W-1:0] addr);
      alloc_reply_type r;
      int              i;
      r.status = STAT_OK;
      r.addr   = '0;
      i = 0;
      while (i < seg_total && !(seg_busy[i] && seg_base[i] == {1'b0, addr})) i++;
      if (i >= seg_total) begin
         r.status = STAT_NOT_FOUND;
         return r;
      end
      seg_busy[i] = 1'b0;
      if (i > 0 && !seg_busy[i - 1] && seg_base[i - 1] + seg_len[i - 1] == seg_base[i]) begin
         seg_len[i - 1] += seg_len[i];
         seg_forget(i);
         i--;
      end
      if (i + 1 < seg_total && !seg_busy[i + 1] &&
          seg_base[i] + seg_len[i] == seg_base[i + 1]) begin
         seg_len[i] += seg_len[i + 1];
         seg_forget(i + 1);
      end
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.req_type <= REQ_ALLOC;
         req_if.req_size <= '0;
         req_if.req_addr <= '0;
         req_gap         <= 0;
      end else if (!req_if.valid || req_done) begin
         if (req_gap > 0) begin
            req_gap      <= req_gap - 1;
            req_if.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            alloc_req_type item;
            item = pending_reqs.pop_front();
            req_if.valid    <= 1'b1;
            req_if.req_type <= item.kind;
            req_if.req_size <= item.size;
            req_if.req_addr <= item.addr;
            req_gap         <= pick_gap();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall    <= rsp_stall - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_done || $urandom_range(0, 99) == 0) rsp_stall <= pick_gap();
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      alloc_reply_type want;
      req_done <= 1'b0;
      rsp_done <= 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_done      <= 1'b1;
            accepted_reqs <= accepted_reqs + 1;
            if (req_if.req_type == REQ_FREE) replies_due.push_back(release_seg(req_if.req_addr));
            else replies_due.push_back(grant_alloc(req_if.req_size));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_done <= 1'b1;
            if (replies_due.size() == 0) begin
               report_mismatch($sformatf("response with none outstanding: status %0d addr %0d",
                                         rsp_if.status, rsp_if.result_addr));
            end else begin
               want = replies_due.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d", rsp_if.status,
                                            want.status));
               if (rsp_if.result_addr !== want.addr)
                  report_mismatch($sformatf("result_addr got %0d want %0d",
                                            rsp_if.result_addr, want.addr));
            end
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      while (accepted_reqs < 400) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (300) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      alloc_req_type item;
      int            phase_kind;
      int            r;
      int            busy_starts[$];

      reset = 1'b1;
      for (int k = 0; k < NSEG; k++) begin
         seg_base[k] = '0;
         seg_len[k]  = '0;
         seg_busy[k] = 1'b0;
      end
      seg_len[0] = REQ_SIZE_W'(REGION);
      seg_total  = 1;

      // directed: zero size, oversize, exact fit, unknown and double free,
      // split, and merges with the neighbor after and on both sides
      pending_reqs.push_back('{REQ_ALLOC, 13'd0,    12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd4097, 12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd8191, 12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd4096, 12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd1,    12'($urandom)});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd4095});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd0});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd0});
      pending_reqs.push_back('{REQ_ALLOC, 13'd100,  12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd200,  12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd300,  12'($urandom)});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd100});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd0});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd300});
      pending_reqs.push_back('{REQ_ALLOC, 13'd1,    12'($urandom)});
      pending_reqs.push_back('{REQ_ALLOC, 13'd4095, 12'($urandom)});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd1});
      pending_reqs.push_back('{REQ_FREE,  13'($urandom), 12'd0});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      phase_kind = 0;
      for (int n = 0; n < RAND_REQS; n++) begin
         while (pending_reqs.size() >= 4) @(posedge clock);
         #1;
         if (n % 100 == 0) begin
            phase_kind = $urandom_range(0, 2);
            calm = ($urandom_range(0, 3) == 0);
         end
         // fill phases favor allocate, drain phases favor free
         r = $urandom_range(0, 99);
         if ((phase_kind == 0 && r < 75) || (phase_kind == 1 && r < 25) ||
             (phase_kind == 2 && r < 50)) begin
            item.kind = REQ_ALLOC;
            item.addr = 12'($urandom);
            r = $urandom_range(0, 99);
            if (r < 5)       item.size = '0;
            else if (r < 10) item.size = 13'($urandom_range(REGION + 1, 8191));
            else if (r < 15) item.size = 13'($urandom_range(1024, REGION));
            else if (r < 30) item.size = 13'($urandom_range(65, 1023));
            else             item.size = 13'($urandom_range(1, 64));
         end else begin
            item.kind = REQ_FREE;
            item.size = 13'($urandom);
            busy_starts.delete();
            for (int k = 0; k < seg_total; k++)
               if (seg_busy[k]) busy_starts.push_back(int'(seg_base[k]));
            r = $urandom_range(0, 99);
            if (r < 85 && busy_starts.size() > 0)
               item.addr = 12'(busy_starts[$urandom_range(0, busy_starts.size() - 1)]);
            else if (r < 92)
               item.addr = 12'(seg_base[$urandom_range(0, seg_total - 1)]);
            else
               item.addr = 12'($urandom);
         end
         pending_reqs.push_back(item);
      end

      while (pending_reqs.size() != 0 || req_if.valid) @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (2 * NSEG + 20) @(posedge clock);
      if (replies_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", replies_due.size()));

      if (mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
design/ffsa_pkg.sv
design/ffsa_if.sv
design/ffsa_seg_mem.sv
design/first_fit_segment_allocator.sv
tb/testbench.sv
